// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the command frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define CFP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cfp_pkg.sv =====
// Constants and types shared by the command frame parser modules.
package cfp_pkg;

  localparam logic [7:0] HdrFirst    = 8'h2C;
  localparam logic [7:0] HdrSecond   = 8'hE4;
  localparam logic [7:0] CmdStop     = 8'h30;
  localparam logic [7:0] CmdMotion   = 8'h31;
  localparam logic [7:0] CmdSpectral = 8'h32;
  localparam logic [7:0] CmdUv       = 8'h33;
  localparam logic [7:0] CmdAll      = 8'h34;

  localparam int         FrameLen     = 9;
  localparam logic [3:0] PosLast      = 4'(FrameLen - 1);
  localparam int         PayloadDepth = 6;

  localparam logic [7:0] FormatReset = 8'd1;
  localparam logic [7:0] ModeReset   = 8'd2;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusBadSum = 1'b1;

  localparam int TdataWidth = 48;

  typedef enum logic [2:0] {
    ActNone,
    ActStop,
    ActMotion,
    ActSpectral,
    ActUv,
    ActAll
  } action_e;

  typedef struct packed {
    logic       status;
    action_e    action;
    logic [7:0] output_format;
    logic [7:0] sleep_time;
    logic [7:0] channel_select;
    logic [7:0] sample_mode;
    logic [7:0] gain_setting;
  } result_t;

endpackage

// ===== hw/rtl/cfp_parser.sv =====
// Byte-level frame hunt, checksum check and settings registers.
`include "assert_macros.svh"

module cfp_parser import cfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o,
  output logic       at_last_o
);

  logic [3:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] format_q, format_d;
  logic [7:0] sleep_q, sleep_d;
  logic [7:0] channel_q, channel_d;
  logic [7:0] mode_q, mode_d;
  logic [7:0] gain_q, gain_d;
  logic [7:0] payload_q [PayloadDepth];
  logic       wr_en;
  logic [2:0] wr_idx;
  logic       status;
  action_e    action;

  assign wr_idx = 3'(pos_q - 4'd2);

  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    format_d    = format_q;
    sleep_d     = sleep_q;
    channel_d   = channel_q;
    mode_d      = mode_q;
    gain_d      = gain_q;
    wr_en       = 1'b0;
    res_valid_o = 1'b0;
    status      = StatusOk;
    action      = ActNone;
    if (byte_valid_i) begin
      if (pos_q == 4'd0) begin
        if (byte_i == HdrFirst) begin
          pos_d = 4'd1;
          sum_d = byte_i;
        end
      end else if (pos_q == 4'd1) begin
        if (byte_i == HdrSecond) begin
          pos_d = 4'd2;
          sum_d = sum_q + byte_i;
        end else begin
          pos_d = 4'd0;
          sum_d = 8'd0;
        end
      end else if (pos_q == 4'd2 && byte_i == 8'd0) begin
        pos_d = 4'd0;
        sum_d = 8'd0;
      end else if (pos_q < PosLast) begin
        wr_en = 1'b1;
        pos_d = pos_q + 4'd1;
        sum_d = sum_q + byte_i;
      end else if (pos_q == PosLast) begin
        res_valid_o = 1'b1;
        pos_d       = 4'd0;
        sum_d       = 8'd0;
        if (byte_i != sum_q) begin
          status = StatusBadSum;
        end else begin
          channel_d = payload_q[3];
          format_d  = payload_q[4];
          sleep_d   = payload_q[5];
          case (payload_q[0])
            CmdStop:     action = ActStop;
            CmdMotion:   action = ActMotion;
            CmdSpectral: action = ActSpectral;
            CmdUv:       action = ActUv;
            CmdAll:      action = ActAll;
            default:     action = ActNone;
          endcase
          if (action != ActNone && action != ActStop) begin
            mode_d = payload_q[1];
          end
          if (action == ActSpectral || action == ActAll) begin
            gain_d = payload_q[2];
          end
        end
      end else begin
        pos_d = 4'd0;
        sum_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 4'd0;
      sum_q     <= 8'd0;
      format_q  <= FormatReset;
      sleep_q   <= 8'd0;
      channel_q <= 8'd0;
      mode_q    <= ModeReset;
      gain_q    <= 8'd0;
    end else begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      format_q  <= format_d;
      sleep_q   <= sleep_d;
      channel_q <= channel_d;
      mode_q    <= mode_d;
      gain_q    <= gain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      payload_q[wr_idx] <= byte_i;
    end
  end

  assign res_o.status         = status;
  assign res_o.action         = action;
  assign res_o.output_format  = format_d;
  assign res_o.sleep_time     = sleep_d;
  assign res_o.channel_select = channel_d;
  assign res_o.sample_mode    = mode_d;
  assign res_o.gain_setting   = gain_d;
  assign at_last_o            = (pos_q == PosLast);

  `CFP_ASSERT(a_pos_range, pos_q <= PosLast, "Frame position ran past the last byte.")
  `CFP_ASSERT_NEXT(a_restart_after_result, res_valid_o, pos_q == 4'd0, "No restart after a result.")
  `CFP_ASSERT(a_bad_sum_no_action, !(res_valid_o && res_o.status == StatusBadSum) || res_o.action == ActNone, "Bad checksum carried an action.")
  `CFP_ASSERT_NEXT(a_bad_sum_keeps, res_valid_o && res_o.status == StatusBadSum, $stable(format_q) && $stable(mode_q) && $stable(gain_q), "Bad checksum changed a setting.")

endmodule

// ===== hw/rtl/command_frame_parser.sv =====
// Top level of the command frame parser: stream ports and result register.
// The block takes one received byte per transaction and can accept a byte in
// every cycle unless a result is still pending at a frame's ninth byte. A
// nine-byte command frame (header 0x2C, 0xE4, non-zero command byte, five
// more bytes, checksum) yields one result transaction in the cycle after its
// ninth byte is taken; every other byte yields nothing. The result waits in
// an output register; input keeps flowing meanwhile, and only the ninth byte
// of a following frame is held off until that earlier result has been taken.
// A good frame reports status 0, the decoded action and the updated settings;
// a checksum mismatch reports status 1, no action and the unchanged settings.
module command_frame_parser import cfp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,  // rx_byte
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // action[2:0], output_format, sleep_time, channel_select, sample_mode,
  // gain_setting, zero fill
  output logic [TdataWidth-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o   // status
);

  logic    in_accept;
  logic    res_valid;
  result_t res;
  logic    at_last;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;

  assign s_axis_tready_o = !(out_valid_q && at_last);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  cfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(in_accept),
    .byte_i      (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .at_last_o   (at_last)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {5'd0, out_res_q.gain_setting, out_res_q.sample_mode,
                            out_res_q.channel_select, out_res_q.sleep_time,
                            out_res_q.output_format, out_res_q.action};

endmodule
